@@ rtl/erc_pkg.sv @@
// ----------------------------------------------------------------------------
// erc_pkg
// Shared constants and codes of the epoch reclamation tracker.
// ----------------------------------------------------------------------------
package erc_pkg;

  localparam int SLOT_COUNT  = 64;
  localparam int QUEUE_DEPTH = 32;
  localparam int HANDLE_BITS = 32;

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int EPOCH_W = 64;
  localparam int TAG_W   = 16;
  localparam int QENT_W  = HANDLE_BITS + TAG_W + EPOCH_W;

  localparam logic [2:0] MODE_CLAIM   = 3'd0;
  localparam logic [2:0] MODE_ENTER   = 3'd1;
  localparam logic [2:0] MODE_EXIT    = 3'd2;
  localparam logic [2:0] MODE_RETIRE  = 3'd3;
  localparam logic [2:0] MODE_RECLAIM = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NESTED    = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_IGNORED   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_FREED     = 3'd5;
  localparam logic [2:0] ST_DONE      = 3'd6;

endpackage

@@ rtl/erc_if.sv @@
// ----------------------------------------------------------------------------
// erc_in_if / erc_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface erc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [5:0]  slot;
  logic        outer;
  logic [31:0] handle;
  logic [15:0] release_tag;
  modport source (output valid, mode, slot, outer, handle, release_tag, input ready);
  modport sink   (input valid, mode, slot, outer, handle, release_tag, output ready);
endinterface

interface erc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  granted_slot;
  logic        was_outer;
  logic [31:0] freed_handle;
  logic [15:0] freed_tag;
  logic [5:0]  freed_count;
  logic        last;
  modport source (output valid, status, granted_slot, was_outer, freed_handle, freed_tag,
                  freed_count, last, input ready);
  modport sink   (input valid, status, granted_slot, was_outer, freed_handle, freed_tag,
                  freed_count, last, output ready);
endinterface

@@ rtl/epoch_reclaim_tracker.sv @@
// ----------------------------------------------------------------------------
// epoch_reclaim_tracker
// Reader slot table, global epoch and retire queue with in-order reclaim.
// ----------------------------------------------------------------------------
// Retire and unknown modes go straight to the result beat; enter and exit first read the slot epoch RAM.
// Claim scans the taken bits one slot per cycle from slot 0 and takes the first free slot.
// Reclaim: a min-epoch scan of the slot RAM, then for each queued entry a queue RAM
// read, then emit or compact, then done.
// One request at a time; output register lets the next request in while a beat waits.
// Reset: slots free and quiescent, epoch 1, queue empty; no clearing pass.
module epoch_reclaim_tracker (
  input  logic clk_i,
  input  logic rst_ni,
  erc_in_if.sink    in_i,
  erc_out_if.source out_o
);
  import erc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EMIT  = 4'd1;
  localparam logic [3:0] S_SLOT  = 4'd2;
  localparam logic [3:0] S_CLAIM = 4'd3;
  localparam logic [3:0] S_MIN   = 4'd4;
  localparam logic [3:0] S_QRD   = 4'd5;
  localparam logic [3:0] S_QEV   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  localparam int SCNT_W = $clog2(SLOT_COUNT + 1);

  logic [3:0] state_q, state_d;

  logic [SLOT_COUNT-1:0] taken_q, ev_q;
  logic [EPOCH_W-1:0]    gepoch_q;
  logic [QCNT_W-1:0]     fill_q;

  logic [2:0]        mode_q;
  logic [SLOT_W-1:0] slot_q;
  logic              outer_q, sok_q;

  logic [2:0]        p_status_q;
  logic [5:0]        p_gslot_q;
  logic              p_wo_q;

  logic [SCNT_W-1:0]  scnt_q;
  logic               pv_q;
  logic [EPOCH_W-1:0] safe_q;
  logic [QCNT_W-1:0]  qi_q, qw_q, qn_q;

  // slot epoch RAM
  logic [EPOCH_W-1:0] se_mem [SLOT_COUNT];
  logic [EPOCH_W-1:0] se_rd_q;
  logic               se_re, se_we;
  logic [SLOT_W-1:0]  se_ra, se_wa;
  logic [EPOCH_W-1:0] se_wd;
  logic               se_rev_q;

  // retire queue RAM: {handle, tag, stamp}
  logic [QENT_W-1:0] q_mem [QUEUE_DEPTH];
  logic [QENT_W-1:0] q_rd_q;
  logic              q_re, q_we;
  logic [QIDX_W-1:0] q_ra, q_wa;
  logic [QENT_W-1:0] q_wd;

  logic              in_fire, out_free;
  logic              slot_ok_in;
  logic              retire_ok, retire_null, retire_full;
  logic [EPOCH_W-1:0] ep_cur;
  logic [HANDLE_BITS-1:0] qh;
  logic [TAG_W-1:0]  qt;
  logic [EPOCH_W-1:0] qs;

  logic        o_ld;
  logic [2:0]  o_status;
  logic [5:0]  o_gslot, o_fc;
  logic        o_wo, o_last;
  logic [31:0] o_fh;
  logic [15:0] o_ft;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_o.valid || out_o.ready;

  assign slot_ok_in  = ({1'b0, in_i.slot} < 7'(SLOT_COUNT)) && taken_q[in_i.slot[SLOT_W-1:0]];
  assign retire_null = (in_i.handle[HANDLE_BITS-1:0] == '0) || (in_i.release_tag == '0);
  assign retire_full = (fill_q >= QCNT_W'(QUEUE_DEPTH));
  assign retire_ok   = in_fire && (in_i.mode == MODE_RETIRE) && !retire_null && !retire_full;

  assign ep_cur = se_rev_q ? se_rd_q : '0;
  assign {qh, qt, qs} = q_rd_q;

  always_comb begin
    se_re = 1'b0;
    se_ra = in_i.slot[SLOT_W-1:0];
    se_we = 1'b0;
    se_wa = slot_q;
    se_wd = '0;
    q_re  = 1'b0;
    q_ra  = qi_q[QIDX_W-1:0];
    q_we  = 1'b0;
    q_wa  = fill_q[QIDX_W-1:0];
    q_wd  = {in_i.handle[HANDLE_BITS-1:0], in_i.release_tag, gepoch_q};
    o_ld  = 1'b0;
    o_status = p_status_q;
    o_gslot  = p_gslot_q;
    o_wo     = p_wo_q;
    o_fh     = '0;
    o_ft     = '0;
    o_fc     = '0;
    o_last   = 1'b1;
    state_d  = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          se_re = (in_i.mode == MODE_ENTER) || (in_i.mode == MODE_EXIT);
          q_we  = retire_ok;
          unique case (in_i.mode) inside
            MODE_CLAIM:             state_d = S_CLAIM;
            MODE_ENTER, MODE_EXIT:  state_d = S_SLOT;
            MODE_RECLAIM:           state_d = S_MIN;
            default:                state_d = S_EMIT;
          endcase
        end
      end
      S_SLOT: begin
        if (sok_q) begin
          if (mode_q == MODE_ENTER && ep_cur == '0) begin
            se_we = 1'b1;
            se_wd = gepoch_q;
          end else if (mode_q == MODE_EXIT && outer_q) begin
            se_we = 1'b1;
          end
        end
        state_d = S_EMIT;
      end
      S_CLAIM: begin
        if (scnt_q == SCNT_W'(SLOT_COUNT) || !taken_q[scnt_q[SLOT_W-1:0]]) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          o_ld    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MIN: begin
        se_ra = scnt_q[SLOT_W-1:0];
        se_re = (scnt_q != SCNT_W'(SLOT_COUNT));
        if (scnt_q == SCNT_W'(SLOT_COUNT) && !pv_q) state_d = S_QRD;
      end
      S_QRD: begin
        if (qi_q < fill_q) begin
          q_re    = 1'b1;
          state_d = S_QEV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_QEV: begin
        if (qs < safe_q) begin
          if (out_free) begin
            o_ld     = 1'b1;
            o_status = ST_FREED;
            o_gslot  = '0;
            o_wo     = 1'b0;
            o_fh     = 32'(qh);
            o_ft     = qt;
            o_last   = 1'b0;
            state_d  = S_QRD;
          end
        end else begin
          q_we    = 1'b1;
          q_wa    = qw_q[QIDX_W-1:0];
          q_wd    = q_rd_q;
          state_d = S_QRD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          o_ld     = 1'b1;
          o_status = ST_DONE;
          o_gslot  = '0;
          o_wo     = 1'b0;
          o_fc     = 6'(qn_q);
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (se_we) se_mem[se_wa] <= se_wd;
    if (se_re) se_rd_q <= se_mem[se_ra];
    if (q_we)  q_mem[q_wa] <= q_wd;
    if (q_re)  q_rd_q <= q_mem[q_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      taken_q   <= '0;
      ev_q      <= '0;
      gepoch_q  <= EPOCH_W'(1);
      fill_q    <= '0;
      se_rev_q  <= 1'b0;
      pv_q      <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (se_re) se_rev_q <= ev_q[se_ra];
      if (se_we) ev_q[se_wa] <= 1'b1;
      if (retire_ok) begin
        fill_q <= fill_q + QCNT_W'(1);
        if (gepoch_q != '1) gepoch_q <= gepoch_q + EPOCH_W'(1);
      end
      if (state_q == S_CLAIM && state_d == S_EMIT && scnt_q != SCNT_W'(SLOT_COUNT))
        taken_q[scnt_q[SLOT_W-1:0]] <= 1'b1;
      if (state_q == S_MIN) pv_q <= se_re;
      if (state_q == S_DONE && o_ld) fill_q <= qw_q;
      if (o_ld) out_o.valid <= 1'b1;
      else if (out_o.ready) out_o.valid <= 1'b0;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= in_i.mode;
      slot_q  <= in_i.slot[SLOT_W-1:0];
      outer_q <= in_i.outer;
      sok_q   <= slot_ok_in;
      scnt_q  <= '0;
      safe_q  <= '1;
      qi_q    <= '0;
      qw_q    <= '0;
      qn_q    <= '0;
      p_gslot_q <= '0;
      p_wo_q    <= 1'b0;
      if (in_i.mode == MODE_RETIRE)
        p_status_q <= retire_null ? ST_IGNORED : (retire_full ? ST_FULL : ST_OK);
      else
        p_status_q <= ST_IGNORED;
    end
    unique case (state_q)
      S_SLOT: begin
        if (!sok_q)                  p_status_q <= ST_IGNORED;
        else if (mode_q == MODE_EXIT) p_status_q <= ST_OK;
        else if (ep_cur != '0)       p_status_q <= ST_NESTED;
        else begin
          p_status_q <= ST_OK;
          p_wo_q     <= 1'b1;
        end
      end
      S_CLAIM: begin
        if (scnt_q == SCNT_W'(SLOT_COUNT)) begin
          p_status_q <= ST_EXHAUSTED;
        end else if (!taken_q[scnt_q[SLOT_W-1:0]]) begin
          p_status_q <= ST_OK;
          p_gslot_q  <= 6'(scnt_q);
        end else begin
          scnt_q <= scnt_q + SCNT_W'(1);
        end
      end
      S_MIN: begin
        if (se_re) scnt_q <= scnt_q + SCNT_W'(1);
        if (pv_q && taken_q[slot_q] && ep_cur != '0 && ep_cur < safe_q) safe_q <= ep_cur;
      end
      S_QEV: begin
        if (qs < safe_q) begin
          if (out_free) begin
            qi_q <= qi_q + QCNT_W'(1);
            qn_q <= qn_q + QCNT_W'(1);
          end
        end else begin
          qi_q <= qi_q + QCNT_W'(1);
          qw_q <= qw_q + QCNT_W'(1);
        end
      end
      default: ;
    endcase
    // slot_q tracks the slot whose epoch is in flight during the min scan
    if (state_q == S_MIN && se_re) slot_q <= scnt_q[SLOT_W-1:0];
    if (o_ld) begin
      out_o.status       <= o_status;
      out_o.granted_slot <= o_gslot;
      out_o.was_outer    <= o_wo;
      out_o.freed_handle <= o_fh;
      out_o.freed_tag    <= o_ft;
      out_o.freed_count  <= o_fc;
      out_o.last         <= o_last;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue fill beyond depth");

  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gepoch_q != '0) else $error("global epoch reached zero");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QEV) |-> (qw_q <= qi_q && qi_q < fill_q))
    else $error("compaction write pointer passed read pointer");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_FREED) |-> !out_o.last)
    else $error("freed beat flagged last");

endmodule

@@ tb/sv/erc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erc_checker
// Watches the request and result channels of the epoch reclamation tracker,
// keeps its own copy of the slot table, global epoch and retire queue, and
// checks every result beat against the oldest predicted result.
// ----------------------------------------------------------------------------
module erc_checker
  import erc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  erc_in_if    req_mon,
  erc_out_if   res_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  granted_slot;
    logic        was_outer;
    logic [31:0] freed_handle;
    logic [15:0] freed_tag;
    logic [5:0]  freed_count;
    logic        last;
  } erc_result_t;

  erc_result_t           result_q[$];
  bit                    taken[SLOT_COUNT];
  bit [EPOCH_W-1:0]      reader_epoch[SLOT_COUNT];
  bit [EPOCH_W-1:0]      cur_epoch;
  bit [31:0]             retired_handle[$];
  bit [15:0]             retired_tag[$];
  bit [EPOCH_W-1:0]      retired_stamp[$];
  int                    fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  function automatic erc_result_t mk(logic [2:0] st, logic [5:0] gs = '0, logic wo = 1'b0,
                                     logic [31:0] fh = '0, logic [15:0] ft = '0,
                                     logic [5:0] fc = '0, logic lst = 1'b1);
    erc_result_t r;
    r.status = st; r.granted_slot = gs; r.was_outer = wo;
    r.freed_handle = fh; r.freed_tag = ft; r.freed_count = fc; r.last = lst;
    return r;
  endfunction

  task automatic report_mismatch(string what, erc_result_t got, erc_result_t exp_r);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp_r);
    fails++;
  endtask

  // append one predicted beat at the tail
  function automatic void queue_result(erc_result_t r);
    result_q = {result_q, r};
  endfunction

  // predict the result beats of one request
  task automatic predict_request(logic [2:0] mode, logic [5:0] slot, logic outer,
                                 logic [31:0] handle, logic [15:0] tag);
    bit               slot_ok;
    bit               found;
    bit [EPOCH_W-1:0] safe;
    int               n;
    int               i;
    slot_ok = taken[slot];
    case (mode)
      MODE_CLAIM: begin
        found = 0;
        for (i = 0; i < SLOT_COUNT && !found; i++) begin
          if (!taken[i]) begin
            taken[i] = 1;
            found    = 1;
            queue_result(mk(ST_OK, i[5:0]));
          end
        end
        if (!found) queue_result(mk(ST_EXHAUSTED));
      end
      MODE_ENTER: begin
        if (!slot_ok) queue_result(mk(ST_IGNORED));
        else if (reader_epoch[slot] != 0) queue_result(mk(ST_NESTED));
        else begin
          reader_epoch[slot] = cur_epoch;
          queue_result(mk(ST_OK, '0, 1'b1));
        end
      end
      MODE_EXIT: begin
        if (!slot_ok) queue_result(mk(ST_IGNORED));
        else begin
          if (outer) reader_epoch[slot] = 0;
          queue_result(mk(ST_OK));
        end
      end
      MODE_RETIRE: begin
        if (handle == 0 || tag == 0) queue_result(mk(ST_IGNORED));
        else if (retired_handle.size() >= QUEUE_DEPTH) queue_result(mk(ST_FULL));
        else begin
          retired_handle = {retired_handle, handle};
          retired_tag    = {retired_tag, tag};
          retired_stamp  = {retired_stamp, cur_epoch};
          if (cur_epoch != '1) cur_epoch++;
          queue_result(mk(ST_OK));
        end
      end
      MODE_RECLAIM: begin
        safe = '1;
        for (i = 0; i < SLOT_COUNT; i++)
          if (taken[i] && reader_epoch[i] != 0 && reader_epoch[i] < safe)
            safe = reader_epoch[i];
        n = 0;
        i = 0;
        while (i < retired_handle.size()) begin
          if (retired_stamp[i] < safe) begin
            queue_result(mk(ST_FREED, '0, 1'b0, retired_handle[i], retired_tag[i],
                            '0, 1'b0));
            retired_handle.delete(i);
            retired_tag.delete(i);
            retired_stamp.delete(i);
            n++;
          end else i++;
        end
        queue_result(mk(ST_DONE, '0, 1'b0, '0, '0, n[5:0]));
      end
      default: queue_result(mk(ST_IGNORED));
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    erc_result_t got;
    erc_result_t exp_r;
    if (!rst_ni) begin
      foreach (taken[i]) begin
        taken[i]        = 0;
        reader_epoch[i] = 0;
      end
      cur_epoch = 1;
      retired_handle.delete();
      retired_tag.delete();
      retired_stamp.delete();
      result_q.delete();
      fails = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got = mk(res_mon.status, res_mon.granted_slot, res_mon.was_outer,
                 res_mon.freed_handle, res_mon.freed_tag, res_mon.freed_count, res_mon.last);
        if (result_q.size() == 0) report_mismatch("unexpected beat", got, '0);
        else begin
          exp_r = result_q.pop_front();
          if (got.status != exp_r.status) report_mismatch("status", got, exp_r);
          if (got.granted_slot != exp_r.granted_slot) report_mismatch("granted_slot", got, exp_r);
          if (got.was_outer != exp_r.was_outer) report_mismatch("was_outer", got, exp_r);
          if (got.freed_handle != exp_r.freed_handle) report_mismatch("freed_handle", got, exp_r);
          if (got.freed_tag != exp_r.freed_tag) report_mismatch("freed_tag", got, exp_r);
          if (got.freed_count != exp_r.freed_count) report_mismatch("freed_count", got, exp_r);
          if (got.last != exp_r.last) report_mismatch("last", got, exp_r);
        end
      end
      if (req_mon.valid && req_mon.ready)
        predict_request(req_mon.mode, req_mon.slot, req_mon.outer, req_mon.handle,
                        req_mon.release_tag);
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the epoch reclamation tracker: directed corner
// cases, then reader/retire/reclaim sequences with random content under
// several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb;
  import erc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   fail_count;
  int   pending;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   claims = 0;

  erc_in_if  req_ch();
  erc_out_if res_ch();

  epoch_reclaim_tracker i_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_ch), .out_o(res_ch));

  erc_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_mon(req_ch), .res_mon(res_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("epoch_reclaim_tracker regression: fail");
      $finish;
    end
  end

  always @(negedge clk_i) res_ch.ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_req(logic [2:0] mode, logic [5:0] slot = '0, logic outer = 1'b0,
                          logic [31:0] handle = '0, logic [15:0] tag = '0);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    req_ch.mode        = mode;
    req_ch.slot        = slot;
    req_ch.outer       = outer;
    req_ch.handle      = handle;
    req_ch.release_tag = tag;
    req_ch.valid       = 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    if (mode == MODE_CLAIM && claims < SLOT_COUNT) claims++;
  endtask

  function automatic logic [5:0] pick_slot();
    if (claims > 0 && $urandom_range(99) < 85) return 6'($urandom_range(claims - 1));
    return 6'($urandom_range(63));
  endfunction

  function automatic logic [31:0] rand_handle();
    return ($urandom_range(99) < 6) ? 32'd0 : $urandom;
  endfunction

  function automatic logic [15:0] rand_tag();
    return ($urandom_range(99) < 6) ? 16'd0 : 16'($urandom_range(1, 65535));
  endfunction

  initial begin
    logic [5:0] rs;
    int         ph;
    int         k;
    int         j;
    req_ch.valid = 1'b0;
    req_ch.mode = '0; req_ch.slot = '0; req_ch.outer = 1'b0;
    req_ch.handle = '0; req_ch.release_tag = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners
    send_req(MODE_RECLAIM);                          // empty queue, no readers
    send_req(MODE_ENTER, 6'd0);                      // unclaimed slot
    send_req(MODE_CLAIM);
    send_req(MODE_CLAIM);
    send_req(MODE_ENTER, 6'd63, 1'b1);               // unclaimed high slot
    send_req(MODE_ENTER, 6'd0);
    send_req(MODE_ENTER, 6'd0);                      // nested
    send_req(MODE_RETIRE, '0, 1'b0, 32'd0, 16'hffff); // null handle
    send_req(MODE_RETIRE, '0, 1'b0, 32'hffff_ffff, 16'd0); // null tag
    send_req(MODE_RETIRE, '0, 1'b0, 32'hffff_ffff, 16'hffff);
    send_req(MODE_RETIRE, '0, 1'b0, 32'h0000_0001, 16'h0001);
    send_req(MODE_RECLAIM);                          // reader pins both
    send_req(MODE_EXIT, 6'd0, 1'b0);                 // inner exit keeps epoch
    send_req(MODE_RECLAIM);
    send_req(MODE_ENTER, 6'd1);
    send_req(MODE_EXIT, 6'd0, 1'b1);
    send_req(MODE_RECLAIM);                          // frees both; slot 1 entered after them
    send_req(MODE_EXIT, 6'd1, 1'b1);
    send_req(MODE_EXIT, 6'd62, 1'b1);                // unclaimed
    send_req(3'd5);
    send_req(3'd6, 6'h3f, 1'b1, 32'hffff_ffff, 16'hffff);
    send_req(3'd7);
    send_req(MODE_RECLAIM);

    // random sequences, four idle/stall mixes
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (k = 0; k < 30; ) begin
        case ($urandom_range(9)) inside
          [0:1]: begin
            send_req(MODE_CLAIM); k++;
          end
          [2:4]: begin
            // reader section: enter, one to four retires, an optional reclaim, exit, reclaim
            rs = pick_slot();
            send_req(MODE_ENTER, rs);
            for (j = $urandom_range(1, 4); j > 0; j--) begin
              send_req(MODE_RETIRE, pick_slot(), 1'($urandom), rand_handle(), rand_tag());
              k++;
            end
            if ($urandom_range(3) == 0) send_req(MODE_RECLAIM);
            send_req(MODE_EXIT, rs, $urandom_range(99) < 80);
            send_req(MODE_RECLAIM);
            k += 3;
          end
          5: begin
            // pin the queue with a long reader, overfill it, then release
            rs = pick_slot();
            send_req(MODE_ENTER, rs, 1'b1);
            for (j = 0; j < 34; j++)
              send_req(MODE_RETIRE, '0, 1'b0, $urandom | 32'd1,
                       16'($urandom_range(1, 65535)));
            send_req(MODE_RECLAIM);
            send_req(MODE_EXIT, rs, 1'b1);
            send_req(MODE_RECLAIM);
            k += 38;
          end
          default: begin
            // noise
            send_req(3'($urandom_range(7)), pick_slot(), 1'($urandom), rand_handle(),
                     rand_tag());
            k++;
          end
        endcase
      end
    end
    // run out the slot table
    while (claims < SLOT_COUNT) send_req(MODE_CLAIM);
    send_req(MODE_CLAIM);
    for (j = 0; j < 64; j++) send_req(MODE_EXIT, j[5:0], 1'b1);
    send_req(MODE_RECLAIM);

    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("epoch_reclaim_tracker regression: pass");
    end else begin
      $display("epoch_reclaim_tracker regression: fail");
    end
    $finish;
  end

endmodule
